// File: rtl/core/glst_pkg.sv
// Shared constants, codes and types of the grid Laplacian stencil.
package glst_pkg;

    // Grid geometry and number format
    localparam int MAX_COLS   = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 17;
    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 11;
    localparam int MODE_W     = 2;
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 32;
    localparam int RES_W      = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 3'd0,
        CFG_COLS = 3'd1,
        CFG_MODE = 3'd2,
        CFG_DX2  = 3'd3,
        CFG_DY2  = 3'd4,
        CFG_DIAG = 3'd5,
        CFG_SIX  = 3'd6
    } glst_cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIVE  = 2'd0,
        MODE_SEVEN = 2'd1,
        MODE_MEHR  = 2'd2
    } glst_mode_t;

    typedef struct packed {
        logic [ROWS_W-1:0]   rows;
        logic [COLS_W-1:0]   cols;
        logic [MODE_W-1:0]   mode;
        logic [WEIGHT_W-1:0] inv_dx2;
        logic [WEIGHT_W-1:0] inv_dy2;
        logic [WEIGHT_W-1:0] inv_diag_h2;
        logic [WEIGHT_W-1:0] inv_six_h2;
    } glst_cfg_t;

    // One 3x3 neighbourhood ready for the arithmetic
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ctr;
        logic signed [SAMPLE_W-1:0] up;
        logic signed [SAMPLE_W-1:0] dn;
        logic signed [SAMPLE_W-1:0] lf;
        logic signed [SAMPLE_W-1:0] rt;
        logic signed [SAMPLE_W-1:0] c0;
        logic signed [SAMPLE_W-1:0] c1;
        logic signed [SAMPLE_W-1:0] c2;
        logic signed [SAMPLE_W-1:0] c3;
        logic                       last;
    } glst_entry_t;

    typedef struct packed {
        logic        push;
        glst_entry_t entry;
    } glst_push_t;

endpackage

// File: rtl/core/glst_ram.sv
// Generic simple dual-port RAM with registered read.
module glst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/glst_front.sv
// Front part: sample intake, grid position, line buffers and 3x3 window.
module glst_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  glst_pkg::glst_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [glst_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [glst_pkg::QCW-1:0]        q_count,
    output glst_pkg::glst_push_t            q_push
);
    import glst_pkg::*;

    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;

    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    logic [COL_W-1:0]           a_col_reg;
    logic                       a_produce_reg;
    logic                       a_last_reg;

    logic signed [SAMPLE_W-1:0] win_reg [6];

    logic [COL_W-1:0]  cols_eff;
    logic [COL_W-1:0]  last_c;
    logic [ROW_W-1:0]  last_r;
    logic              accept;
    logic [SAMPLE_W-1:0] top_raw;
    logic [SAMPLE_W-1:0] mid_raw;
    logic signed [SAMPLE_W-1:0] top;
    logic signed [SAMPLE_W-1:0] mid;

    // Effective grid size: zero acts as one, columns capped at MAX_COLS
    always_comb
    begin
        if (cfg.cols == '0)
        begin
            cols_eff = COL_W'(1);
        end
        else if (32'(cfg.cols) > 32'(MAX_COLS))
        begin
            cols_eff = COL_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = COL_W'(cfg.cols);
        end
        last_c = cols_eff + COL_W'(1);
        if (cfg.rows == '0)
        begin
            last_r = ROW_W'(2);
        end
        else
        begin
            last_r = ROW_W'(cfg.rows) + ROW_W'(1);
        end
    end

    // Hold off intake while the queue could not take what is in flight
    assign in_stall = (QCW'(q_count) + QCW'(a_valid_reg)) >= QCW'(QDEPTH);
    assign accept   = in_valid && !in_stall;

    // Advance the column and row position on each transfer
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (col_pos_reg >= last_c)
            begin
                col_pos_next = '0;
                row_pos_next = (row_pos_reg >= last_r) ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            a_valid_reg   <= accept;
        end
    end

    // Capture the sample and its classification alongside the line read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg  <= sample_value;
            a_col_reg     <= col_pos_reg;
            a_produce_reg <= (row_pos_reg >= ROW_W'(2)) && (col_pos_reg >= COL_W'(2));
            a_last_reg    <= (row_pos_reg >= last_r) && (col_pos_reg >= last_c);
        end
    end

    // Line buffers: read at intake, write back the shifted column in the cycle after
    glst_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_upper (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_col_reg),
        .wdata (mid_raw),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (top_raw)
    );

    glst_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_middle (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_col_reg),
        .wdata (a_sample_reg),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (mid_raw)
    );

    assign top = $signed(top_raw);
    assign mid = $signed(mid_raw);

    // Shift the window by one column per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (a_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= a_sample_reg;
        end
    end

    // Hand an interior neighbourhood to the queue
    always_comb
    begin
        q_push.push        = a_valid_reg && a_produce_reg;
        q_push.entry.ctr   = win_reg[4];
        q_push.entry.up    = win_reg[3];
        q_push.entry.dn    = win_reg[5];
        q_push.entry.lf    = win_reg[1];
        q_push.entry.rt    = mid;
        q_push.entry.c0    = win_reg[0];
        q_push.entry.c1    = win_reg[2];
        q_push.entry.c2    = top;
        q_push.entry.c3    = a_sample_reg;
        q_push.entry.last  = a_last_reg;
    end

endmodule

// File: rtl/core/glst_queue.sv
// Short queue of neighbourhoods between the front and the back.
module glst_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  glst_pkg::glst_push_t     q_push,
    input  logic                     pop,
    output glst_pkg::glst_entry_t    head,
    output logic                     empty,
    output logic [glst_pkg::QCW-1:0] count
);
    import glst_pkg::*;

    glst_entry_t      ent_reg [QDEPTH];
    logic [QAW-1:0]   head_reg, head_next;
    logic [QAW-1:0]   tail_reg, tail_next;
    logic [QCW-1:0]   count_reg, count_next;

    // Move pointers and fill count
    always_comb
    begin
        head_next  = pop ? head_reg + QAW'(1) : head_reg;
        tail_next  = q_push.push ? tail_reg + QAW'(1) : tail_reg;
        count_next = count_reg + QCW'(q_push.push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            ent_reg[tail_reg] <= q_push.entry;
        end
    end

    assign head  = ent_reg[head_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: rtl/core/glst_back.sv
// Back part: stencil sums, weighting multiplies, term sum and saturation.
module glst_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  glst_pkg::glst_cfg_t               cfg,
    input  glst_pkg::glst_entry_t             head,
    input  logic                              empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [glst_pkg::RES_W-1:0] laplacian_value,
    output logic                              frame_last
);
    import glst_pkg::*;

    localparam int S1_W   = SAMPLE_W + 3;
    localparam int DW     = SAMPLE_W + 6;
    localparam int DL     = DW / 2;
    localparam int DH     = DW - DL;
    localparam int PL_W   = DL + WEIGHT_W;
    localparam int PH_W   = DH + WEIGHT_W + 1;
    localparam int FULL_W = DW + WEIGHT_W + 1;
    localparam int TERM_W = FULL_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    logic en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;

    logic signed [S1_W-1:0]     s1_dx_reg, s1_dy_reg, s1_axis_reg, s1_corner_reg;
    logic signed [SAMPLE_W-1:0] s1_ctr_reg;

    logic signed [DW-1:0]   s2_op_reg [3];
    logic [WEIGHT_W-1:0]    s2_w_reg  [3];
    logic signed [DW-1:0]   d_diag, d_mehr;
    logic signed [DW-1:0]   op_next [3];
    logic [WEIGHT_W-1:0]    w_next  [3];

    logic [PL_W-1:0]          s3_pl_reg [3];
    logic signed [PH_W-1:0]   s3_ph_reg [3];
    logic signed [TERM_W-1:0] s4_term_reg [3];
    logic signed [FULL_W-1:0] full [3];

    logic signed [SUM_W-1:0]  sum;
    logic signed [RES_W-1:0]  sat;
    logic signed [RES_W-1:0]  res_reg;

    // Whole pipeline moves unless a finished result is held at the output
    assign en  = !(v5_reg && out_stall);
    assign pop = en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: axis differences and neighbour sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg     <= S1_W'(head.up) + S1_W'(head.dn) - (S1_W'(head.ctr) <<< 1);
            s1_dy_reg     <= S1_W'(head.lf) + S1_W'(head.rt) - (S1_W'(head.ctr) <<< 1);
            s1_axis_reg   <= S1_W'(head.up) + S1_W'(head.dn)
                             + S1_W'(head.lf) + S1_W'(head.rt);
            s1_corner_reg <= S1_W'(head.c0) + S1_W'(head.c1)
                             + S1_W'(head.c2) + S1_W'(head.c3);
            s1_ctr_reg    <= head.ctr;
            l1_reg        <= head.last;
        end
    end

    // Stage 2: diagonal and Mehrstellen sums, pick operands and weights by mode
    always_comb
    begin
        d_diag = DW'(s1_corner_reg) - (DW'(s1_ctr_reg) <<< 2);
        d_mehr = (DW'(s1_axis_reg) <<< 2) + DW'(s1_corner_reg)
                 - (DW'(s1_ctr_reg) <<< 4) - (DW'(s1_ctr_reg) <<< 2);
        op_next[0] = DW'(s1_dx_reg);
        op_next[1] = DW'(s1_dy_reg);
        op_next[2] = d_diag;
        w_next[0]  = cfg.inv_dx2;
        w_next[1]  = cfg.inv_dy2;
        w_next[2]  = '0;
        case (cfg.mode)
            MODE_SEVEN:
            begin
                w_next[2] = cfg.inv_diag_h2;
            end
            MODE_MEHR:
            begin
                op_next[0] = d_mehr;
                w_next[0]  = cfg.inv_six_h2;
                w_next[1]  = '0;
            end
            default:
            begin
                w_next[2] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_op_reg[k] <= op_next[k];
                s2_w_reg[k]  <= w_next[k];
            end
            l2_reg <= l1_reg;
        end
    end

    // Stage 3: split each product into two partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_pl_reg[k] <= PL_W'(s2_op_reg[k][DL-1:0]) * PL_W'(s2_w_reg[k]);
                s3_ph_reg[k] <= PH_W'($signed(s2_op_reg[k][DW-1:DL]))
                                * $signed({1'b0, s2_w_reg[k]});
            end
            l3_reg <= l2_reg;
        end
    end

    // Stage 4: join partial products, drop fraction rounding toward minus infinity
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            full[k] = (FULL_W'(s3_ph_reg[k]) <<< DL) + FULL_W'($signed({1'b0, s3_pl_reg[k]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_term_reg[k] <= $signed(full[k][FULL_W-1:FRAC_BITS]);
            end
            l4_reg <= l3_reg;
        end
    end

    // Stage 5: add the terms and saturate to the result width
    always_comb
    begin
        sum = SUM_W'(s4_term_reg[0]) + SUM_W'(s4_term_reg[1]) + SUM_W'(s4_term_reg[2]);
        if ((&sum[SUM_W-1:RES_W-1]) || !(|sum[SUM_W-1:RES_W-1]))
        begin
            sat = sum[RES_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(RES_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sat;
            l5_reg  <= l4_reg;
        end
    end

    assign out_valid       = v5_reg;
    assign laplacian_value = res_reg;
    assign frame_last      = l5_reg;

endmodule

// File: rtl/core/grid_laplacian_stencil.sv
// Top level of the streaming grid Laplacian stencil.
//
//  Channel  Handshake           Payload
//  input    in_valid/in_stall   sample_value (s32, Q16.16)
//  output   out_valid/out_stall laplacian_value (s48, Q32.16), frame_last
//  config   cfg_we              cfg_index, cfg_data (write only)
//
// One sample per cycle sustained while in_stall is low; one result per interior point.
// The rate is set by the single read port of each line-buffer RAM.
// Reset clears positions, window, queue and pipeline valids; line RAMs are not cleared.
// An output stall freezes the back pipeline; the front keeps taking samples until
// the four-entry queue is full.
module grid_laplacian_stencil (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [glst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [glst_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [glst_pkg::SAMPLE_W-1:0]  sample_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [glst_pkg::RES_W-1:0]     laplacian_value,
    output logic                                  frame_last
);
    import glst_pkg::*;

    glst_cfg_t   cfg_reg;
    glst_push_t  q_push;
    glst_entry_t q_head;
    logic        q_empty;
    logic        q_pop;
    logic [QCW-1:0] q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows        <= ROWS_W'(64);
            cfg_reg.cols        <= COLS_W'(64);
            cfg_reg.mode        <= MODE_FIVE;
            cfg_reg.inv_dx2     <= WEIGHT_W'(65536);
            cfg_reg.inv_dy2     <= WEIGHT_W'(65536);
            cfg_reg.inv_diag_h2 <= WEIGHT_W'(16384);
            cfg_reg.inv_six_h2  <= WEIGHT_W'(10923);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS: cfg_reg.rows        <= cfg_data[ROWS_W-1:0];
                CFG_COLS: cfg_reg.cols        <= cfg_data[COLS_W-1:0];
                CFG_MODE: cfg_reg.mode        <= cfg_data[MODE_W-1:0];
                CFG_DX2:  cfg_reg.inv_dx2     <= cfg_data[WEIGHT_W-1:0];
                CFG_DY2:  cfg_reg.inv_dy2     <= cfg_data[WEIGHT_W-1:0];
                CFG_DIAG: cfg_reg.inv_diag_h2 <= cfg_data[WEIGHT_W-1:0];
                CFG_SIX:  cfg_reg.inv_six_h2  <= cfg_data[WEIGHT_W-1:0];
                default:  cfg_reg.rows        <= cfg_reg.rows;
            endcase
        end
    end

    glst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .q_count      (q_count),
        .q_push       (q_push)
    );

    glst_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .empty  (q_empty),
        .count  (q_count)
    );

    glst_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (q_head),
        .empty           (q_empty),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .laplacian_value (laplacian_value),
        .frame_last      (frame_last)
    );

`ifndef ASSERT_OFF
    // Queue never takes an entry while full unless one is popped in the same cycle
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> (q_count < QCW'(QDEPTH)) || q_pop)
        else $error("stencil queue overflow");

    // Queue never pops while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("stencil queue underflow");

    // A held result freezes the back pipeline
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !q_pop)
        else $error("back pipeline moved under an output stall");

    // A full queue holds off intake
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == QCW'(QDEPTH)) |-> in_stall)
        else $error("intake open with a full queue");
`endif

endmodule

// File: tb/sv/tb_stencil_pkg.sv
// Scoreboard with a bit-exact stencil predictor for the grid Laplacian testbench.
package tb_stencil_pkg;

    import glst_pkg::*;

    // Mode code left unused by the block; it behaves as the five-point stencil
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF_FFFF;
    localparam logic signed [79:0] SAT_LO = -SAT_HI - 80'sd1;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic                    last;
    } laplacian_t;

    // Exact product of a stencil sum and a weight, floored by FRAC_BITS
    function automatic logic signed [79:0] apply_weight(logic signed [79:0] sum,
                                                        logic [WEIGHT_W-1:0] weight);
        logic signed [79:0] wide_weight;
        wide_weight = {48'd0, weight};
        return (sum * wide_weight) >>> FRAC_BITS;
    endfunction

    class laplacian_scoreboard;

        logic [ROWS_W-1:0]          rows;
        logic [COLS_W-1:0]          cols;
        logic [MODE_W-1:0]          mode;
        logic [WEIGHT_W-1:0]        dx2;
        logic [WEIGHT_W-1:0]        dy2;
        logic [WEIGHT_W-1:0]        diag;
        logic [WEIGHT_W-1:0]        six;
        logic signed [SAMPLE_W-1:0] upper_row [LINE_DEPTH];
        logic signed [SAMPLE_W-1:0] middle_row [LINE_DEPTH];
        logic signed [SAMPLE_W-1:0] win [6];
        int unsigned                col_pos;
        int unsigned                row_pos;
        laplacian_t                 expected_q [$];
        int                         failures;

        function new();
            rows = 16'd64;
            cols = 11'd64;
            mode = MODE_FIVE;
            dx2  = 32'd65536;
            dy2  = 32'd65536;
            diag = 32'd16384;
            six  = 32'd10923;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_pos  = 0;
            row_pos  = 0;
            failures = 0;
        endfunction

        function void write_reg(glst_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROWS: rows = data[ROWS_W-1:0];
                CFG_COLS: cols = data[COLS_W-1:0];
                CFG_MODE: mode = data[MODE_W-1:0];
                CFG_DX2:  dx2  = data;
                CFG_DY2:  dy2  = data;
                CFG_DIAG: diag = data;
                CFG_SIX:  six  = data;
                default: ;
            endcase
        endfunction

        function int unsigned eff_rows();
            return (rows == 0) ? 1 : rows;
        endfunction

        function int unsigned eff_cols();
            int unsigned n;
            n = (cols == 0) ? 1 : cols;
            return (n > MAX_COLS) ? MAX_COLS : n;
        endfunction

        function int unsigned frame_len();
            return (eff_rows() + 2) * (eff_cols() + 2);
        endfunction

        function bit at_frame_start();
            return (col_pos == 0) && (row_pos == 0);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted sample and advance the grid state
        function void note_sample(logic signed [SAMPLE_W-1:0] bot_s);
            int unsigned                last_c;
            int unsigned                last_r;
            int unsigned                c;
            int unsigned                r;
            logic signed [SAMPLE_W-1:0] top_s;
            logic signed [SAMPLE_W-1:0] mid_s;
            logic signed [79:0]         ctr;
            logic signed [79:0]         up;
            logic signed [79:0]         dn;
            logic signed [79:0]         lf;
            logic signed [79:0]         rt;
            logic signed [79:0]         corners;
            logic signed [79:0]         acc;
            laplacian_t                 res;

            last_c = eff_cols() + 1;
            last_r = eff_rows() + 1;
            c      = col_pos;
            r      = row_pos;
            top_s  = upper_row[c];
            mid_s  = middle_row[c];

            if (r >= 2 && c >= 2)
            begin
                ctr     = win[4];
                up      = win[3];
                dn      = win[5];
                lf      = win[1];
                rt      = mid_s;
                corners = win[0];
                corners = corners + win[2];
                corners = corners + top_s;
                corners = corners + bot_s;
                if (mode == MODE_MEHR)
                begin
                    acc = apply_weight(-20 * ctr + 4 * (up + dn + lf + rt) + corners, six);
                end
                else
                begin
                    acc = apply_weight(up + dn - 2 * ctr, dx2)
                        + apply_weight(lf + rt - 2 * ctr, dy2);
                    if (mode == MODE_SEVEN)
                        acc = acc + apply_weight(corners - 4 * ctr, diag);
                end
                // Clamp to the 48-bit result range
                if (acc > SAT_HI)
                    acc = SAT_HI;
                if (acc < SAT_LO)
                    acc = SAT_LO;
                res.value = acc[RES_W-1:0];
                res.last  = (r >= last_r) && (c >= last_c);
                expected_q.push_back(res);
            end

            // Shift the window and refresh both line stores
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top_s;
            win[4] = mid_s;
            win[5] = bot_s;
            upper_row[c]  = mid_s;
            middle_row[c] = bot_s;

            // Advance the raster position, wrapping at or beyond the last padded one
            if (c >= last_c)
            begin
                col_pos = 0;
                row_pos = (r >= last_r) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic signed [RES_W-1:0] value, logic last);
            laplacian_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %0d, frame_last %0b", $time, value, last);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: laplacian_value mismatch, expected %0d, actual %0d",
                         $time, want.value, value);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
                failures++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench of the streaming grid Laplacian stencil.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import glst_pkg::*;
    import tb_stencil_pkg::*;

    // Covers the pipeline stages plus the queue between front and back, with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 30;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [RES_W-1:0]    laplacian_value;
    logic                       frame_last;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int sample_count       = 0;

    laplacian_scoreboard sb = new();

    grid_laplacian_stencil DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_value    (sample_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .laplacian_value (laplacian_value),
        .frame_last      (frame_last)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(laplacian_value, frame_last);
    end

    // Abort if no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 1 << 18));
        endcase
    endfunction

    // Mostly small grids so that frames complete often
    function automatic glst_cfg_t rand_config();
        glst_cfg_t cfg;
        if ($urandom_range(9) == 0)
            cfg.rows = 16'($urandom_range(7, 20));
        else
            cfg.rows = 16'($urandom_range(0, 6));
        cfg.cols        = 11'($urandom_range(0, 12));
        cfg.mode        = 2'($urandom_range(0, 3));
        cfg.inv_dx2     = rand_weight();
        cfg.inv_dy2     = rand_weight();
        cfg.inv_diag_h2 = rand_weight();
        cfg.inv_six_h2  = rand_weight();
        return cfg;
    endfunction

    task automatic reg_write(input glst_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
    endtask

    // Hold the sender until every predicted result has arrived, then let the pipe empty
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input glst_cfg_t cfg);
        settle_block();
        reg_write(CFG_ROWS, 32'(cfg.rows));
        reg_write(CFG_COLS, 32'(cfg.cols));
        reg_write(CFG_MODE, 32'(cfg.mode));
        reg_write(CFG_DX2,  cfg.inv_dx2);
        reg_write(CFG_DY2,  cfg.inv_dy2);
        reg_write(CFG_DIAG, cfg.inv_diag_h2);
        reg_write(CFG_SIX,  cfg.inv_six_h2);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample, with random idle cycles ahead of it, and hold it until the transfer
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(v);
        sample_count++;
    endtask

    // Stream random samples up to the end of the current frame
    task automatic run_frame();
        do
        begin
            if ($urandom_range(199) == 0)
                settle_block();
            send_sample(rand_sample());
        end
        while (!sb.at_frame_start());
    endtask

    // One 1x1 interior grid: centre sample ringed by eight equal ones
    task automatic send_cross(input logic signed [SAMPLE_W-1:0] centre,
                              input logic signed [SAMPLE_W-1:0] rim);
        for (int i = 0; i < 9; i++)
            send_sample((i == 4) ? centre : rim);
    endtask

    initial
    begin
        glst_cfg_t cfg;
        int        phase_start;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ROWS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample_value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Saturate high with the five-point stencil and full weights
        cfg = '{rows: 16'd1, cols: 11'd1, mode: MODE_FIVE, inv_dx2: 32'hFFFF_FFFF,
                inv_dy2: 32'hFFFF_FFFF, inv_diag_h2: 32'hFFFF_FFFF, inv_six_h2: 32'hFFFF_FFFF};
        set_config(cfg);
        send_cross(32'sh8000_0000, 32'sh7FFF_FFFF);

        // Saturate low with the diagonals added
        cfg.mode = MODE_SEVEN;
        set_config(cfg);
        send_cross(32'sh7FFF_FFFF, 32'sh8000_0000);

        // Mehrstellen form, other weights zeroed
        cfg = '{rows: 16'd1, cols: 11'd1, mode: MODE_MEHR, inv_dx2: '0, inv_dy2: '0,
                inv_diag_h2: '0, inv_six_h2: 32'hFFFF_FFFF};
        set_config(cfg);
        run_frame();

        // Zero sizes with the unused mode code
        cfg = '{rows: 16'd0, cols: 11'd0, mode: MODE_SPARE, inv_dx2: 32'd65536,
                inv_dy2: 32'd65536, inv_diag_h2: 32'd16384, inv_six_h2: 32'd10923};
        set_config(cfg);
        run_frame();

        // Reconfigure mid-frame: columns lowered past the position, rows cut short
        cfg = '{rows: 16'hFFFF, cols: 11'd2, mode: MODE_SEVEN, inv_dx2: rand_weight(),
                inv_dy2: rand_weight(), inv_diag_h2: rand_weight(), inv_six_h2: rand_weight()};
        set_config(cfg);
        repeat (15) send_sample(rand_sample());
        cfg.rows       = 16'd5;
        cfg.cols       = 11'd1;
        cfg.mode       = MODE_MEHR;
        cfg.inv_six_h2 = rand_weight();
        set_config(cfg);
        run_frame();

        // Random frames under each idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 49;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 49;
                end
                default:
                begin
                    sender_idle_pct    = 12;
                    receiver_stall_pct = 12;
                end
            endcase

            // Columns above the limit: one capped padded row, then narrow the grid
            if (phase == 3)
            begin
                cfg      = rand_config();
                cfg.rows = 16'd1;
                cfg.cols = 11'h7FF;
                set_config(cfg);
                repeat (LINE_DEPTH + 2) send_sample(rand_sample());
                cfg.cols = 11'd2;
                set_config(cfg);
                run_frame();
            end

            phase_start = sample_count;
            while (sample_count - phase_start < PHASE_ITEMS)
            begin
                cfg = rand_config();
                set_config(cfg);
                // Now and then change settings part-way, never widening the grid
                if ($urandom_range(7) == 0)
                begin
                    repeat ($urandom_range(1, sb.frame_len() - 1)) send_sample(rand_sample());
                    cfg      = rand_config();
                    cfg.cols = 11'($urandom_range(0, sb.eff_cols()));
                    set_config(cfg);
                end
                run_frame();
            end
        end

        // Drain and report
        receiver_stall_pct = 0;
        settle_block();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
